FILE: rtl/core/rfb_pkg.sv
// ----------------------------------------------------------------------------
// rfb_pkg: shared types and constants of the radio frame builder.
// Holds the payload structs of both channels, the command that passes from
// the front end to the back end, the register map and the CRC-32 byte step.
// ----------------------------------------------------------------------------
package rfb_pkg;

	localparam int MAX_PAYLOAD = 10;

	localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [31:0] ERR_MAX  = 32'hFFFFFFFF;

	localparam logic [1:0] REQ_PAYLOAD = 2'd0;
	localparam logic [1:0] REQ_REPORT  = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [1:0] RK_FRAME   = 2'd0;
	localparam logic [1:0] RK_LEN_ERR = 2'd1;
	localparam logic [1:0] RK_DONE    = 2'd2;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_ADDRESS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIO_CHANNEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROTO_VERSION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_KIND   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FLAGS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SEQ_START     = 3'd5;

	localparam logic [15:0] RST_DEST_ADDRESS  = 16'd2;
	localparam logic [7:0]  RST_RADIO_CHANNEL = 8'h17;
	localparam logic [3:0]  RST_PROTO_VERSION = 4'h1;
	localparam logic [3:0]  RST_DEVICE_KIND   = 4'h1;
	localparam logic [3:0]  RST_HEADER_FLAGS  = 4'h0;
	localparam logic [15:0] RST_SEQ_START     = 16'd0;

	localparam logic [4:0] STEP_DEST_HI = 5'd0;
	localparam logic [4:0] STEP_DEST_LO = 5'd1;
	localparam logic [4:0] STEP_CHAN    = 5'd2;
	localparam logic [4:0] STEP_HDR0    = 5'd3;
	localparam logic [4:0] STEP_HDR1    = 5'd4;
	localparam logic [4:0] STEP_SEQ_LO  = 5'd5;
	localparam logic [4:0] STEP_SEQ_HI  = 5'd6;
	localparam logic [4:0] STEP_TS0     = 5'd7;
	localparam logic [4:0] STEP_TS1     = 5'd8;
	localparam logic [4:0] STEP_TS2     = 5'd9;
	localparam logic [4:0] STEP_TS3     = 5'd10;
	localparam logic [4:0] STEP_LEN     = 5'd11;
	localparam logic [4:0] STEP_PAYLOAD = 5'd12;
	localparam logic [4:0] STEP_CRC0    = 5'd13;
	localparam logic [4:0] STEP_CRC1    = 5'd14;
	localparam logic [4:0] STEP_CRC2    = 5'd15;
	localparam logic [4:0] STEP_CRC3    = 5'd16;

	typedef enum logic [1:0] {
		CMD_LONE = 2'd0,
		CMD_OPEN = 2'd1,
		CMD_BYTE = 2'd2
	} cmd_op_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_len;
		logic [3:0]  msg_kind;
		logic [31:0] time_stamp;
		logic        link_ok;
	} item_t;

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic        frame_last;
		logic [1:0]  result_kind;
		logic [15:0] seq_now;
		logic [31:0] link_error_count;
	} result_t;

	typedef struct packed {
		logic [15:0] dest_address;
		logic [7:0]  radio_channel;
		logic [3:0]  proto_version;
		logic [3:0]  device_kind;
		logic [3:0]  header_flags;
	} cfg_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [1:0]  lone_kind;
		logic        last;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_len;
		logic [3:0]  msg_kind;
		logic [31:0] time_stamp;
		logic [15:0] seq;
		logic [31:0] errs;
	} cmd_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {data, 24'h0};
		for (int i = 0; i < 8; i++) begin
			if (c[31]) begin
				c = {c[30:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[30:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/rfb_cmd_queue.sv
// ----------------------------------------------------------------------------
// rfb_cmd_queue: two-entry command queue.
// Decouples the front end, which takes one item per beat while the queue has
// room, from the back end, which emits up to seventeen beats for one command.
// ----------------------------------------------------------------------------
module rfb_cmd_queue
	import rfb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic q_full,
	input  logic rd_en,
	output logic q_valid,
	output cmd_t head
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign q_full  = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/core/rfb_front.sv
// ----------------------------------------------------------------------------
// rfb_front: front end of the frame builder.
// Holds the config registers, sequence number, error count and frame position,
// classifies each accepted item and queues a command unless its code is unused.
// ----------------------------------------------------------------------------
module rfb_front
	import rfb_pkg::*;
#(
	parameter int MaxPayload = MAX_PAYLOAD
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  item_t                 item,
	output logic                  full,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg,
	input  logic                  q_full,
	output logic                  cmd_push,
	output cmd_t                  cmd
);

	localparam int LenW = $clog2(MaxPayload + 1);

	cfg_t            cfg_q;
	logic [15:0]     seq_start_q;
	logic [15:0]     seq_q;
	logic [31:0]     err_q;
	logic            in_frame_q;
	logic [LenW-1:0] left_q;

	logic [15:0]     seq_nxt;
	logic [31:0]     err_nxt;
	logic            in_frame_nxt;
	logic [LenW-1:0] left_nxt;
	logic            accept;

	assign accept    = push && !q_full;
	assign full      = q_full;
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_comb begin
		seq_nxt          = seq_q;
		err_nxt          = err_q;
		in_frame_nxt     = in_frame_q;
		left_nxt         = left_q;
		cmd_push         = 1'b0;
		cmd.op           = CMD_LONE;
		cmd.lone_kind    = RK_DONE;
		cmd.last         = 1'b0;
		cmd.payload_byte = item.payload_byte;
		cmd.payload_len  = item.payload_len;
		cmd.msg_kind     = item.msg_kind;
		cmd.time_stamp   = item.time_stamp;
		if (accept) begin
			case (item.req_type)
				REQ_REPORT: begin
					cmd_push = 1'b1;
					if (item.link_ok) begin
						seq_nxt = seq_q + 16'd1;
					end else if (err_q != ERR_MAX) begin
						err_nxt = err_q + 32'd1;
					end
				end
				REQ_RESTART: begin
					cmd_push = 1'b1;
					seq_nxt  = seq_start_q;
				end
				REQ_PAYLOAD: begin
					cmd_push = 1'b1;
					if (in_frame_q) begin
						cmd.op       = CMD_BYTE;
						left_nxt     = left_q - LenW'(1);
						cmd.last     = (left_nxt == '0);
						in_frame_nxt = !cmd.last;
					end else if (item.payload_len == 8'd0 ||
						item.payload_len > 8'(MaxPayload)) begin
						cmd.lone_kind = RK_LEN_ERR;
					end else begin
						cmd.op       = CMD_OPEN;
						left_nxt     = item.payload_len[LenW-1:0] - LenW'(1);
						cmd.last     = (left_nxt == '0);
						in_frame_nxt = !cmd.last;
					end
				end
				default: begin
				end
			endcase
		end
		cmd.seq  = seq_nxt;
		cmd.errs = err_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_address  <= RST_DEST_ADDRESS;
			cfg_q.radio_channel <= RST_RADIO_CHANNEL;
			cfg_q.proto_version <= RST_PROTO_VERSION;
			cfg_q.device_kind   <= RST_DEVICE_KIND;
			cfg_q.header_flags  <= RST_HEADER_FLAGS;
			seq_start_q         <= RST_SEQ_START;
			seq_q               <= '0;
			err_q               <= '0;
			in_frame_q          <= 1'b0;
			left_q              <= '0;
		end else begin
			seq_q      <= seq_nxt;
			err_q      <= err_nxt;
			in_frame_q <= in_frame_nxt;
			left_q     <= left_nxt;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_DEST_ADDRESS:  cfg_q.dest_address  <= cfg_data;
					CFG_RADIO_CHANNEL: cfg_q.radio_channel <= cfg_data[7:0];
					CFG_PROTO_VERSION: cfg_q.proto_version <= cfg_data[3:0];
					CFG_DEVICE_KIND:   cfg_q.device_kind   <= cfg_data[3:0];
					CFG_HEADER_FLAGS:  cfg_q.header_flags  <= cfg_data[3:0];
					CFG_SEQ_START:     seq_start_q         <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/core/rfb_back.sv
// ----------------------------------------------------------------------------
// rfb_back: back end of the frame builder.
// Walks each command through its byte steps, one beat per cycle while output
// is free, keeps the frame's running CRC-32 and registers the result beat.
// ----------------------------------------------------------------------------
module rfb_back
	import rfb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_valid,
	input  cmd_t    head,
	output logic    q_pop,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	cmd_t        cur_q;
	logic        cur_valid_q;
	logic [4:0]  step_q;
	logic [31:0] crc_q;
	result_t     out_q;
	logic        out_valid_q;

	logic        out_free;
	logic        emit;
	logic        final_step;
	logic        crc_upd;
	logic [31:0] crc_in;
	logic [31:0] crc_fin;
	logic [7:0]  byte_sel;
	result_t     res;

	assign out_free = !out_valid_q || pop;
	assign emit     = cur_valid_q && out_free;
	assign q_pop    = q_valid && (!cur_valid_q || (emit && final_step));
	assign crc_in   = (step_q == STEP_HDR0) ? CRC_INIT : crc_q;
	assign crc_fin  = ~crc_q;
	assign empty    = !out_valid_q;
	assign result   = out_q;

	always_comb begin
		unique case (cur_q.op)
			CMD_OPEN, CMD_BYTE: begin
				final_step = (step_q == STEP_PAYLOAD && !cur_q.last) ||
					(step_q == STEP_CRC3);
				crc_upd = (step_q >= STEP_HDR0) && (step_q <= STEP_PAYLOAD);
			end
			default: begin
				final_step = 1'b1;
				crc_upd    = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (step_q)
			STEP_DEST_HI: byte_sel = cfg.dest_address[15:8];
			STEP_DEST_LO: byte_sel = cfg.dest_address[7:0];
			STEP_CHAN:    byte_sel = cfg.radio_channel;
			STEP_HDR0:    byte_sel = {cur_q.msg_kind, cfg.proto_version};
			STEP_HDR1:    byte_sel = {cfg.header_flags, cfg.device_kind};
			STEP_SEQ_LO:  byte_sel = cur_q.seq[7:0];
			STEP_SEQ_HI:  byte_sel = cur_q.seq[15:8];
			STEP_TS0:     byte_sel = cur_q.time_stamp[7:0];
			STEP_TS1:     byte_sel = cur_q.time_stamp[15:8];
			STEP_TS2:     byte_sel = cur_q.time_stamp[23:16];
			STEP_TS3:     byte_sel = cur_q.time_stamp[31:24];
			STEP_LEN:     byte_sel = cur_q.payload_len;
			STEP_PAYLOAD: byte_sel = cur_q.payload_byte;
			STEP_CRC0:    byte_sel = crc_fin[7:0];
			STEP_CRC1:    byte_sel = crc_fin[15:8];
			STEP_CRC2:    byte_sel = crc_fin[23:16];
			STEP_CRC3:    byte_sel = crc_fin[31:24];
			default:      byte_sel = 8'd0;
		endcase
	end

	always_comb begin
		res.seq_now          = cur_q.seq;
		res.link_error_count = cur_q.errs;
		if (cur_q.op == CMD_OPEN || cur_q.op == CMD_BYTE) begin
			res.frame_byte  = byte_sel;
			res.frame_last  = (step_q == STEP_CRC3);
			res.result_kind = RK_FRAME;
		end else begin
			res.frame_byte  = 8'd0;
			res.frame_last  = 1'b1;
			res.result_kind = cur_q.lone_kind;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= head;
		end
		if (emit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= STEP_DEST_HI;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			priority if (q_pop) begin
				cur_valid_q <= 1'b1;
				step_q      <= (head.op == CMD_BYTE) ? STEP_PAYLOAD : STEP_DEST_HI;
			end else if (emit && final_step) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				step_q <= step_q + 5'd1;
			end else begin
			end
			if (emit && crc_upd) begin
				crc_q <= crc32_byte(crc_in, byte_sel);
			end
			priority if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end else begin
			end
		end
	end

endmodule

FILE: rtl/core/radio_frame_builder_crc32.sv
// ----------------------------------------------------------------------------
// radio_frame_builder_crc32: byte-serial builder of outgoing radio frames.
// Payload items open and fill frames that close with a little-endian CRC-32;
// link reports and restarts update the sequence number and error count.
// ----------------------------------------------------------------------------
// The block emits one result beat per cycle unless an unpopped result waits.
// A payload item that opens a frame yields thirteen beats, or seventeen when
// it is also the last byte, a later payload item yields one beat, or five
// when it closes the frame, a link report, a restart or a payload item with
// a bad length yields one beat, and an item with the unused request code
// yields none. The byte sequencer of the back end, which feeds the output
// register, sets this rate. Items enter the two-entry command queue one per
// cycle while it has room, also while results wait.
module radio_frame_builder_crc32
	import rfb_pkg::*;
#(
	parameter int MaxPayload = MAX_PAYLOAD
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  item_t                 item,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	logic q_full;
	logic q_valid;
	logic q_pop;
	logic cmd_push;
	cmd_t cmd;
	cmd_t head;

	rfb_front #(
		.MaxPayload(MaxPayload)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg),
		.q_full   (q_full),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	rfb_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (cmd),
		.q_full (q_full),
		.rd_en  (q_pop),
		.q_valid(q_valid),
		.head   (head)
	);

	rfb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.q_valid(q_valid),
		.head   (head),
		.q_pop  (q_pop),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule

FILE: rtl/core/rfb_checker.sv
// ----------------------------------------------------------------------------
// rfb_checker: port-level checks of the frame builder.
// Watches the result channel for stall behavior, lone result framing and a
// link error count that never falls.
// ----------------------------------------------------------------------------
module rfb_checker
	import rfb_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    empty,
	input logic    pop,
	input result_t result
);

	logic        err_seen_q;
	logic [31:0] last_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
			last_err_q <= '0;
		end else if (!empty && pop) begin
			err_seen_q <= 1'b1;
			last_err_q <= result.link_error_count;
		end
	end

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while stalled");

	a_lone_framing: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.result_kind != RK_FRAME |->
			result.frame_last && result.frame_byte == 8'd0)
		else $error("lone result not framed as last with zero byte");

	a_err_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && err_seen_q |-> result.link_error_count >= last_err_q)
		else $error("link error count decreased");

endmodule

bind radio_frame_builder_crc32 rfb_checker u_rfb_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.empty (empty),
	.pop   (pop),
	.result(result)
);

FILE: test/tb_radio_frame_builder_crc32.sv
// ----------------------------------------------------------------------------
// tb_radio_frame_builder_crc32: self-checking testbench of the frame builder.
// A short table of directed items opens the run, followed by random frames,
// link reports and restarts under several register settings. Every accepted
// item is fed to a local model of the framer, and its beats, CRC-32 included,
// or a row's fixed beat are compared field by field with each popped beat.
// ----------------------------------------------------------------------------
module tb_radio_frame_builder_crc32
	import rfb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int PHASE_ITEMS   = 50;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	item_t                 item;
	logic                  empty;
	logic                  pop;
	result_t               result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Register copies and framer state of the local model.
	logic [15:0] cfg_dest;
	logic [7:0]  cfg_chan;
	logic [3:0]  cfg_ver;
	logic [3:0]  cfg_dev;
	logic [3:0]  cfg_flags;
	logic [15:0] cfg_seq_start;
	logic [15:0] seq_cnt;
	logic [31:0] crc_run;
	logic [5:0]  bytes_due;
	logic        frame_open;
	logic [31:0] err_cnt;
	bit          model_keep = 1'b1;

	result_t  frame_beats_due[$];
	dir_row_t dir_rows[$];
	result_t  beat_want;
	int       mismatches = 0;
	int       cycles = 0;
	int       burst_left = 0;
	bit       hold_req = 1'b0;

	radio_frame_builder_crc32 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
	endtask

	function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] a;
		a = acc ^ {b, 24'h0};
		repeat (8) begin
			a = a[31] ? ((a << 1) ^ CRC_POLY) : (a << 1);
		end
		return a;
	endfunction

	function automatic result_t lone_beat(input logic [1:0] kind, input logic [15:0] seq,
			input logic [31:0] errs);
		return {8'h00, 1'b1, kind, seq, errs};
	endfunction

	task automatic put_beat(input logic [7:0] b, input logic last, input logic [1:0] kind);
		if (model_keep) begin
			frame_beats_due.push_back({b, last, kind, seq_cnt, err_cnt});
		end
	endtask

	task automatic build_frame_beats(input item_t it);
		logic [7:0]  hdr [9];
		logic [31:0] crc_out;
		case (it.req_type)
			REQ_REPORT: begin
				if (it.link_ok) begin
					seq_cnt = seq_cnt + 16'd1;
				end else if (err_cnt != ERR_MAX) begin
					err_cnt = err_cnt + 32'd1;
				end
				put_beat(8'h00, 1'b1, RK_DONE);
			end
			REQ_RESTART: begin
				seq_cnt = cfg_seq_start;
				put_beat(8'h00, 1'b1, RK_DONE);
			end
			REQ_PAYLOAD: begin
				if (!frame_open && (it.payload_len == 8'd0 || it.payload_len > MAX_PAYLOAD)) begin
					put_beat(8'h00, 1'b1, RK_LEN_ERR);
				end else begin
					if (!frame_open) begin
						put_beat(cfg_dest[15:8], 1'b0, RK_FRAME);
						put_beat(cfg_dest[7:0], 1'b0, RK_FRAME);
						put_beat(cfg_chan, 1'b0, RK_FRAME);
						hdr[0] = {it.msg_kind, cfg_ver};
						hdr[1] = {cfg_flags, cfg_dev};
						hdr[2] = seq_cnt[7:0];
						hdr[3] = seq_cnt[15:8];
						hdr[4] = it.time_stamp[7:0];
						hdr[5] = it.time_stamp[15:8];
						hdr[6] = it.time_stamp[23:16];
						hdr[7] = it.time_stamp[31:24];
						hdr[8] = it.payload_len;
						crc_run = CRC_INIT;
						foreach (hdr[i]) begin
							crc_run = crc_step(crc_run, hdr[i]);
							put_beat(hdr[i], 1'b0, RK_FRAME);
						end
						bytes_due = it.payload_len[5:0];
						frame_open = 1'b1;
					end
					crc_run = crc_step(crc_run, it.payload_byte);
					put_beat(it.payload_byte, 1'b0, RK_FRAME);
					bytes_due = bytes_due - 6'd1;
					if (bytes_due == 6'd0) begin
						crc_out = crc_run ^ CRC_INIT;
						put_beat(crc_out[7:0], 1'b0, RK_FRAME);
						put_beat(crc_out[15:8], 1'b0, RK_FRAME);
						put_beat(crc_out[23:16], 1'b0, RK_FRAME);
						put_beat(crc_out[31:24], 1'b1, RK_FRAME);
						crc_run = CRC_INIT;
						frame_open = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic item_t mk_item(input logic [1:0] req, input logic [7:0] pb,
			input logic [7:0] len, input logic [3:0] kind, input logic [31:0] ts,
			input logic ok);
		return {req, pb, len, kind, ts, ok};
	endfunction

	function automatic item_t rand_item(input logic [1:0] req);
		return {req, 8'($urandom), 8'($urandom), 4'($urandom), 32'($urandom), 1'($urandom)};
	endfunction

	function automatic logic [1:0] pick_side_req();
		case ($urandom_range(0, 4))
			0, 1: return REQ_REPORT;
			2, 3: return REQ_RESTART;
			default: return REQ_UNUSED;
		endcase
	endfunction

	function automatic void add_row(input item_t it, input bit typed = 1'b0,
			input result_t want = '0);
		dir_row_t r;
		r.it = it;
		r.typed = typed;
		r.want = want;
		dir_rows.push_back(r);
	endfunction

	// Offers one item in the sender's burst pattern and predicts it once accepted.
	task automatic offer(input item_t it, input bit typed = 1'b0, input result_t want = '0);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 5);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		if (typed) begin
			model_keep = 1'b0;
			build_frame_beats(it);
			model_keep = 1'b1;
			frame_beats_due.push_back(want);
		end else begin
			build_frame_beats(it);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (frame_beats_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_DEST_ADDRESS:  cfg_dest = data;
			CFG_RADIO_CHANNEL: cfg_chan = data[7:0];
			CFG_PROTO_VERSION: cfg_ver = data[3:0];
			CFG_DEVICE_KIND:   cfg_dev = data[3:0];
			CFG_HEADER_FLAGS:  cfg_flags = data[3:0];
			CFG_SEQ_START:     cfg_seq_start = data;
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [CFG_DATA_W-1:0] data, input bit scramble);
		for (int k = CFG_DEST_ADDRESS; k <= CFG_SEQ_START; k++) begin
			write_reg(CFG_IDX_W'(k), scramble ? CFG_DATA_W'($urandom) : data);
		end
	endtask

	task automatic run_traffic(input int n);
		int    sent;
		int    len;
		int    r;
		item_t it;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				len = ($urandom_range(0, 6) == 0) ? MAX_PAYLOAD : $urandom_range(1, 4);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 9) == 0) begin
						offer(rand_item(pick_side_req()));
					end
					it = rand_item(REQ_PAYLOAD);
					if (i == 0) begin
						it.payload_len = 8'(len);
					end
					offer(it);
					sent++;
					// Now and then a frame is abandoned and later bytes extend it.
					if (i > 0 && $urandom_range(0, 29) == 0) begin
						break;
					end
				end
			end else if (r < 80) begin
				it = rand_item(REQ_PAYLOAD);
				it.payload_len = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(MAX_PAYLOAD + 1, 255));
				offer(it);
				sent++;
			end else if (r < 97) begin
				it = rand_item(pick_side_req());
				offer(it);
				if (it.req_type != REQ_UNUSED) begin
					sent++;
				end
			end else begin
				offer(rand_item(REQ_UNUSED));
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (frame_beats_due.size() == 0) begin
				report_mismatch($sformatf("beat %h with nothing expected", result));
			end else begin
				beat_want = frame_beats_due.pop_front();
				if (result.frame_byte !== beat_want.frame_byte) begin
					report_mismatch($sformatf("frame_byte %h, want %h",
						result.frame_byte, beat_want.frame_byte));
				end
				if (result.frame_last !== beat_want.frame_last) begin
					report_mismatch($sformatf("frame_last %b, want %b",
						result.frame_last, beat_want.frame_last));
				end
				if (result.result_kind !== beat_want.result_kind) begin
					report_mismatch($sformatf("result_kind %0d, want %0d",
						result.result_kind, beat_want.result_kind));
				end
				if (result.seq_now !== beat_want.seq_now) begin
					report_mismatch($sformatf("seq_now %h, want %h",
						result.seq_now, beat_want.seq_now));
				end
				if (result.link_error_count !== beat_want.link_error_count) begin
					report_mismatch($sformatf("link_error_count %h, want %h",
						result.link_error_count, beat_want.link_error_count));
				end
			end
		end
	end

	initial begin : rx_side
		int          hold_cnt;
		int          k;
		logic [15:0] pat;
		hold_cnt = 0;
		k = 0;
		pat = '1;
		pop <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = HOLD_CYCLES;
			end
			if (k % 48 == 0) begin
				pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
			end
			if (hold_cnt != 0) begin
				hold_cnt--;
				pop <= 1'b0;
			end else begin
				pop <= pat[k % 16];
			end
			k++;
		end
	end

	initial begin : tx_side
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cfg_dest = RST_DEST_ADDRESS;
		cfg_chan = RST_RADIO_CHANNEL;
		cfg_ver = RST_PROTO_VERSION;
		cfg_dev = RST_DEVICE_KIND;
		cfg_flags = RST_HEADER_FLAGS;
		cfg_seq_start = RST_SEQ_START;
		seq_cnt = 16'd0;
		crc_run = CRC_INIT;
		bytes_due = 6'd0;
		frame_open = 1'b0;
		err_cnt = 32'd0;

		add_row(mk_item(REQ_RESTART, 8'h00, 8'h00, 4'h0, 32'h0, 1'b0), 1'b1,
			lone_beat(RK_DONE, 16'd0, 32'd0));
		add_row(mk_item(REQ_REPORT, 8'hFF, 8'hFF, 4'hF, 32'hFFFFFFFF, 1'b0), 1'b1,
			lone_beat(RK_DONE, 16'd0, 32'd1));
		add_row(mk_item(REQ_REPORT, 8'h00, 8'h00, 4'h0, 32'h0, 1'b1), 1'b1,
			lone_beat(RK_DONE, 16'd1, 32'd1));
		add_row(mk_item(REQ_PAYLOAD, 8'h33, 8'd0, 4'h1, 32'h0, 1'b0), 1'b1,
			lone_beat(RK_LEN_ERR, 16'd1, 32'd1));
		add_row(mk_item(REQ_PAYLOAD, 8'h44, 8'(MAX_PAYLOAD + 1), 4'h6, 32'h1, 1'b1), 1'b1,
			lone_beat(RK_LEN_ERR, 16'd1, 32'd1));
		add_row(mk_item(REQ_PAYLOAD, 8'hFF, 8'hFF, 4'hF, 32'hFFFFFFFF, 1'b1), 1'b1,
			lone_beat(RK_LEN_ERR, 16'd1, 32'd1));
		add_row(mk_item(REQ_UNUSED, 8'hFF, 8'd1, 4'hF, 32'hFFFFFFFF, 1'b1));
		add_row(mk_item(REQ_PAYLOAD, 8'hFF, 8'd1, 4'hF, 32'hFFFFFFFF, 1'b1));
		add_row(mk_item(REQ_PAYLOAD, 8'h00, 8'd1, 4'h0, 32'h00000000, 1'b0));
		add_row(mk_item(REQ_PAYLOAD, 8'h5A, 8'(MAX_PAYLOAD), 4'h1, 32'h12345678, 1'b0));
		add_row(mk_item(REQ_REPORT, 8'hA5, 8'd0, 4'h2, 32'h0, 1'b0));
		add_row(mk_item(REQ_PAYLOAD, 8'hC3, 8'd0, 4'h3, 32'hDEADBEEF, 1'b1));
		add_row(mk_item(REQ_RESTART, 8'h11, 8'd5, 4'h4, 32'h0, 1'b1));
		add_row(mk_item(REQ_UNUSED, 8'h22, 8'd0, 4'h5, 32'h0, 1'b0));
		for (int i = 0; i < MAX_PAYLOAD - 2; i++) begin
			add_row(mk_item(REQ_PAYLOAD, 8'(i * 37 + 1), 8'(i * 29), 4'(i), 32'(i), 1'(i)));
		end
		add_row(mk_item(REQ_PAYLOAD, 8'h80, 8'd2, 4'h6, 32'h80000001, 1'b0));
		add_row(mk_item(REQ_REPORT, 8'h00, 8'd0, 4'h0, 32'h0, 1'b1));
		add_row(mk_item(REQ_PAYLOAD, 8'h7F, 8'd9, 4'h9, 32'h0, 1'b0));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			offer(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
		end
		drain();

		// Top of every range; the restart and good report then wrap the sequence.
		write_all(16'hFFFF, 1'b0);
		write_reg(CFG_UNMAPPED_LO, 16'($urandom));
		write_reg(CFG_UNMAPPED_HI, 16'($urandom));
		offer(rand_item(REQ_RESTART));
		offer(mk_item(REQ_REPORT, 8'h00, 8'h00, 4'h0, 32'h0, 1'b1));
		run_traffic(PHASE_ITEMS);
		drain();

		write_all(16'h0000, 1'b0);
		hold_req = 1'b1;
		run_traffic(PHASE_ITEMS);
		drain();

		write_all(16'h0000, 1'b1);
		run_traffic(PHASE_ITEMS / 2);
		drain();
		run_traffic(PHASE_ITEMS / 2);
		drain();

		write_all(16'h0000, 1'b1);
		run_traffic(PHASE_ITEMS);
		drain();

		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/rfb_pkg.sv
rtl/core/rfb_cmd_queue.sv
rtl/core/rfb_front.sv
rtl/core/rfb_back.sv
rtl/core/radio_frame_builder_crc32.sv
rtl/core/rfb_checker.sv
test/tb_radio_frame_builder_crc32.sv
